### design/lgwc_pkg.sv
// ----------------------------------------------------------------------------
// Labeled graph walk check package
// Shared widths, codes and control structs of the labeled graph walk check.
// ----------------------------------------------------------------------------
package lgwc_pkg;

  localparam int unsigned MaxVerticesDefault = 16;

  localparam int unsigned IndexW = 4;
  localparam int unsigned LabelW = 8;
  localparam int unsigned RowW   = 16;
  localparam int unsigned CountW = 5;
  localparam int unsigned EntryW = LabelW + RowW;

  localparam int unsigned AddrW = 3;
  localparam int unsigned DataW = 32;

  localparam logic [CountW-1:0]  CountReset     = CountW'(16);
  localparam logic [AddrW-3:0]   RegVertexCount = '0;

  localparam logic OpWrite  = 1'b0;
  localparam logic OpSymbol = 1'b1;

  typedef struct packed {
    logic              start;
    logic              first;
    logic              last;
    logic [LabelW-1:0] symbol;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic ok;
  } status_t;

endpackage

### design/lgwc_vertex_mem.sv
// ----------------------------------------------------------------------------
// Vertex memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lgwc_vertex_mem #(
  parameter int unsigned Depth = lgwc_pkg::MaxVerticesDefault,
  parameter int unsigned AW    = $clog2(Depth)
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [AW-1:0]               waddr_i,
  input  logic [lgwc_pkg::EntryW-1:0] wdata_i,
  input  logic                        re_i,
  input  logic [AW-1:0]               raddr_i,
  output logic [lgwc_pkg::EntryW-1:0] rdata_o
);
  import lgwc_pkg::*;

  logic [EntryW-1:0] mem_q [Depth];
  logic [EntryW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/lgwc_scan.sv
// ----------------------------------------------------------------------------
// Frontier scan unit
// Reads every active vertex once per symbol and updates the frontier mask.
// ----------------------------------------------------------------------------
module lgwc_scan #(
  parameter int unsigned MaxVertices = lgwc_pkg::MaxVerticesDefault,
  parameter int unsigned AW          = $clog2(MaxVertices),
  parameter int unsigned CW          = $clog2(MaxVertices + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lgwc_pkg::cmd_t              cmd_i,
  input  logic [CW-1:0]               active_i,
  input  logic                        res_ready_i,
  output lgwc_pkg::status_t           status_o,
  output logic                        re_o,
  output logic [AW-1:0]               raddr_o,
  input  logic [lgwc_pkg::EntryW-1:0] rdata_i
);
  import lgwc_pkg::*;

  localparam int unsigned EW = (MaxVertices > RowW) ? MaxVertices : RowW;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StScan  = 3'd1;
  localparam logic [2:0] StDrain = 3'd2;
  localparam logic [2:0] StFin   = 3'd3;
  localparam logic [2:0] StDone  = 3'd4;

  logic [2:0]             state_q, state_d;
  logic [CW-1:0]          cnt_q, cnt_nxt;
  logic                   rd_vld_q;
  logic [AW-1:0]          rd_idx_q;
  logic [MaxVertices-1:0] match_q, reach_q, frontier_q, frontier_new;
  logic                   first_q, last_q, ok_q;
  logic [LabelW-1:0]      sym_q;
  logic [LabelW-1:0]      rd_label;
  logic [EW-1:0]          row_ext;

  assign rd_label     = rdata_i[EntryW-1:RowW];
  assign row_ext      = EW'(rdata_i[RowW-1:0]);
  assign cnt_nxt      = cnt_q + CW'(1);
  assign frontier_new = first_q ? match_q : (match_q & reach_q);

  assign re_o    = (state_q == StScan);
  assign raddr_o = cnt_q[AW-1:0];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (cmd_i.start) begin
          state_d = (active_i == '0) ? StFin : StScan;
        end
      end
      StScan: begin
        if (cnt_nxt == active_i) begin
          state_d = StDrain;
        end
      end
      StDrain: state_d = StFin;
      StFin:   state_d = last_q ? StDone : StIdle;
      StDone: begin
        if (res_ready_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      rd_vld_q   <= 1'b0;
      frontier_q <= '0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= (state_q == StScan);
      if (state_q == StFin) begin
        frontier_q <= frontier_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= cnt_q[AW-1:0];
    if (state_q == StIdle && cmd_i.start) begin
      first_q <= cmd_i.first;
      last_q  <= cmd_i.last;
      sym_q   <= cmd_i.symbol;
      match_q <= '0;
      reach_q <= '0;
      cnt_q   <= '0;
    end else begin
      if (state_q == StScan) begin
        cnt_q <= cnt_nxt;
      end
      if (rd_vld_q) begin
        match_q[rd_idx_q] <= (rd_label == sym_q);
        if (frontier_q[rd_idx_q]) begin
          reach_q <= reach_q | row_ext[MaxVertices-1:0];
        end
      end
    end
    if (state_q == StFin) begin
      ok_q <= (frontier_new != '0);
    end
  end

  assign status_o.busy = (state_q != StIdle);
  assign status_o.done = (state_q == StDone);
  assign status_o.ok   = ok_q;

endmodule

### design/labeled_graph_walk_check_unit.sv
// ----------------------------------------------------------------------------
// Labeled graph walk check unit
// Holds a labeled directed graph and checks label sequences against walks.
// ----------------------------------------------------------------------------
// The input channel carries write beats and symbol beats. A write beat
// stores one vertex label and adjacency row. A symbol beat scans the
// active vertices through the single read port of the vertex memory, one
// vertex per cycle; the active vertex count is vertex_count clamped to
// MaxVertices. A symbol beat with the last mark then waits in a done state
// until the output register is free and loads its path_ok beat into it.
// The output register lets the next input beat be accepted while a result
// waits; a further result waits inside the scan unit, with the input
// stalled, until the receiver takes the pending one. Reset clears the
// frontier and sets vertex_count to 16; vertex memory contents are
// undefined until written. vertex_count is to be written by the user
// through the APB port only while idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module labeled_graph_walk_check_unit #(
  parameter int unsigned MaxVertices = lgwc_pkg::MaxVerticesDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lgwc_pkg::AddrW-1:0]  paddr,
  input  logic [lgwc_pkg::DataW-1:0]  pwdata,
  output logic [lgwc_pkg::DataW-1:0]  prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        operation_i,
  input  logic [lgwc_pkg::IndexW-1:0] vertex_index_i,
  input  logic [lgwc_pkg::LabelW-1:0] vertex_label_i,
  input  logic [lgwc_pkg::RowW-1:0]   adjacency_row_i,
  input  logic [lgwc_pkg::LabelW-1:0] symbol_i,
  input  logic                        first_symbol_i,
  input  logic                        last_symbol_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        path_ok_o
);
  import lgwc_pkg::*;

  localparam int unsigned AW = $clog2(MaxVertices);
  localparam int unsigned CW = $clog2(MaxVertices + 1);

  logic [CountW-1:0] count_q;
  logic [CW-1:0]     active;
  logic              in_accept, res_ready;
  logic [31:0]       idx_wide;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [EntryW-1:0] mem_rdata;
  cmd_t              cmd;
  status_t           status;
  logic              out_valid_q, path_ok_q;

  assign pready = 1'b1;
  assign prdata = (paddr[AddrW-1:2] == RegVertexCount) ? DataW'(count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CountReset;
    end else if (psel && penable && pwrite && pready &&
                 paddr[AddrW-1:2] == RegVertexCount) begin
      count_q <= pwdata[CountW-1:0];
    end
  end

  assign active = (32'(count_q) > 32'(MaxVertices)) ? CW'(MaxVertices) : CW'(count_q);

  assign in_ready_o = !status.busy;
  assign in_accept  = in_valid_i && in_ready_o;
  assign idx_wide   = 32'(vertex_index_i);
  assign mem_we     = in_accept && (operation_i == OpWrite) && (idx_wide < 32'(MaxVertices));

  assign cmd.start  = in_accept && (operation_i == OpSymbol);
  assign cmd.first  = first_symbol_i;
  assign cmd.last   = last_symbol_i;
  assign cmd.symbol = symbol_i;

  assign res_ready = !out_valid_q || out_ready_i;

  lgwc_vertex_mem #(
    .Depth (MaxVertices)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (idx_wide[AW-1:0]),
    .wdata_i ({vertex_label_i, adjacency_row_i}),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  lgwc_scan #(
    .MaxVertices (MaxVertices)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .active_i    (active),
    .res_ready_i (res_ready),
    .status_o    (status),
    .re_o        (mem_re),
    .raddr_o     (mem_raddr),
    .rdata_i     (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (status.done && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (status.done && res_ready) begin
      path_ok_q <= status.ok;
    end
  end

  assign out_valid_o = out_valid_q;
  assign path_ok_o   = path_ok_q;

endmodule

### design/lgwc_checker.sv
// ----------------------------------------------------------------------------
// Labeled graph walk check port checker
// Port-level properties of the walk check unit, bound to the top level.
// ----------------------------------------------------------------------------
module lgwc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic operation_i,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic path_ok_o
);
  import lgwc_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(path_ok_o))
    else $error("Stalled result beat changed or dropped.");

  a_write_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && operation_i == OpWrite |=> in_ready_o)
    else $error("Write beat did not complete in one cycle.");

  a_symbol_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && operation_i == OpSymbol |=> !in_ready_o)
    else $error("Symbol beat did not start a scan.");

  a_result_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("Result beat appeared without a scan in progress.");

endmodule

bind labeled_graph_walk_check_unit lgwc_checker u_checker (.*);
